FILE: rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin tick scheduler package
// Shared sizes, request codes and time limits for the scheduler and its RAMs.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // Job table depth and the index/count widths that follow from it
    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    // Field widths
    localparam int REQ_W    = 2;
    localparam int BURST_W  = 16;
    localparam int QUANT_W  = 16;
    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 20;

    // APB register map
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 2;
    localparam logic [APB_AW-1:0] ADDR_QUANTUM = '0;
    localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd4;

    // Saturation value of the time counter
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

endpackage

FILE: rtl/core/round_robin_tick_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin tick scheduler
// Loads job bursts, then hands out one time unit per tick in round-robin
// order with a programmable quantum, reporting completion times.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one request item: load a
//   burst, advance one tick, or clear all jobs. Only tick items produce a
//   result item on the output channel (o_out_valid/i_out_ready).
//   Load, clear and unknown requests are handled in the idle state; the block
//   stays ready for the next item.
//   A tick whose current job keeps running passes through the check, run
//   and output states; when the slice ends, a scan state first walks the
//   job table to the next job with time left, or on to the output state if
//   none has any. A tick with no jobs loaded goes straight to output. The
//   scan walks one entry per cycle over the single read port of the RAMs.
//   The block takes one item at a time; o_in_ready is low while a tick is
//   being worked on and returns high once its result moves to the output.
//   Results sit in an output register; a new item is accepted while a result
//   waits. If the receiver stalls, a finished tick holds in the sequencer
//   until the output register frees.
//   Reset clears the job table state and sets the quantum to 4; a clear item
//   does the same but keeps the quantum. The user writes the quantum over APB
//   at address 0 while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module round_robin_tick_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rrts_pkg::APB_AW-1:0]  paddr,
    input  logic [rrts_pkg::APB_DW-1:0]  pwdata,
    output logic [rrts_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // Request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rrts_pkg::REQ_W-1:0]   i_req_type,
    input  logic [rrts_pkg::BURST_W-1:0] i_burst_time,
    // Result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rrts_pkg::SLOT_W-1:0]  o_slot_job,
    output logic                         o_idle,
    output logic                         o_finished,
    output logic [rrts_pkg::TIME_W-1:0]  o_wait_time,
    output logic [rrts_pkg::TIME_W-1:0]  o_turnaround_time
);

    localparam int IDX_W   = rrts_pkg::IDX_W;
    localparam int CNT_W   = rrts_pkg::CNT_W;
    localparam int BURST_W = rrts_pkg::BURST_W;
    localparam int QUANT_W = rrts_pkg::QUANT_W;
    localparam int TIME_W  = rrts_pkg::TIME_W;
    localparam int SLOT_W  = rrts_pkg::SLOT_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]         r_state;
    logic [QUANT_W-1:0] r_quantum;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_cur;
    logic [IDX_W-1:0]   r_cand;
    logic [CNT_W-1:0]   r_scan;
    logic [QUANT_W-1:0] r_slice;
    logic [TIME_W-1:0]  r_now;
    logic               r_started;

    // Pending result
    logic [SLOT_W-1:0]  r_res_slot;
    logic               r_res_idle;
    logic               r_res_fin;
    logic [TIME_W-1:0]  r_res_wait;
    logic [TIME_W-1:0]  r_res_tat;

    // Output register
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_idle;
    logic               r_out_fin;
    logic [TIME_W-1:0]  r_out_wait;
    logic [TIME_W-1:0]  r_out_tat;

    // RAM ports
    logic               rem_we;
    logic               burst_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [BURST_W-1:0] rem_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [BURST_W-1:0] rem_rdata;
    logic [BURST_W-1:0] burst_rdata;

    logic               in_acc;
    logic               cfg_wr;
    logic               out_free;
    logic               tick_idle;
    logic               can_load;
    logic [IDX_W-1:0]   cur_next;
    logic [IDX_W-1:0]   cand_next;
    logic               keep_cur;
    logic [BURST_W-1:0] rem_dec;
    logic [TIME_W-1:0]  now_inc;
    logic [TIME_W-1:0]  burst_ext;
    logic [TIME_W-1:0]  wait_val;

    assign in_acc    = i_in_valid && o_in_ready;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr == rrts_pkg::ADDR_QUANTUM);
    assign out_free  = !r_out_valid || i_out_ready;
    assign tick_idle = (r_count == '0) || (CNT_W'(r_cur) >= r_count);
    assign can_load  = !r_started && (r_count < CNT_W'(rrts_pkg::MAX_JOBS));

    // Round-robin successors with wrap at the job count
    assign cur_next  = ((CNT_W'(r_cur) + CNT_W'(1)) == r_count) ? '0 : r_cur + IDX_W'(1);
    assign cand_next = ((CNT_W'(r_cand) + CNT_W'(1)) == r_count) ? '0 : r_cand + IDX_W'(1);

    // Current job keeps the unit while it has time left and slice room
    assign keep_cur  = (rem_rdata != '0) && (r_slice < r_quantum);

    // Run arithmetic: one decrement, saturating time step, wait subtract
    assign rem_dec   = rem_rdata - BURST_W'(1);
    assign now_inc   = (r_now == rrts_pkg::TIME_MAX) ? r_now : r_now + TIME_W'(1);
    assign burst_ext = TIME_W'(burst_rdata);
    assign wait_val  = (now_inc >= burst_ext) ? now_inc - burst_ext : '0;

    // RAM control
    always_comb begin
        rem_we    = 1'b0;
        burst_we  = 1'b0;
        ram_waddr = r_cur;
        rem_wdata = rem_dec;
        ram_re    = 1'b0;
        ram_raddr = r_cur;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_req_type == rrts_pkg::REQ_LOAD) && can_load) begin
                    rem_we    = 1'b1;
                    burst_we  = 1'b1;
                    ram_waddr = r_count[IDX_W-1:0];
                    rem_wdata = i_burst_time;
                end
                if (in_acc && (i_req_type == rrts_pkg::REQ_TICK) && !tick_idle) begin
                    ram_re = 1'b1;
                end
            end
            ST_CHK: begin
                if (!keep_cur) begin
                    ram_re    = 1'b1;
                    ram_raddr = cur_next;
                end
            end
            ST_SCAN: begin
                if ((rem_rdata == '0) && (r_scan != r_count)) begin
                    ram_re    = 1'b1;
                    ram_raddr = cand_next;
                end
            end
            ST_RUN: begin
                rem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    rrts_ram #(
        .WIDTH (BURST_W),
        .DEPTH (rrts_pkg::MAX_JOBS)
    ) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (ram_waddr),
        .i_wdata (rem_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rem_rdata)
    );

    rrts_ram #(
        .WIDTH (BURST_W),
        .DEPTH (rrts_pkg::MAX_JOBS)
    ) u_burst_ram (
        .i_clk   (i_clk),
        .i_we    (burst_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_burst_time),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (burst_rdata)
    );

    // Quantum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= rrts_pkg::QUANTUM_RST;
        end else if (cfg_wr) begin
            r_quantum <= pwdata[QUANT_W-1:0];
        end
    end

    // Sequencer and scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cur     <= '0;
            r_slice   <= '0;
            r_now     <= '0;
            r_started <= 1'b0;
            r_cand    <= '0;
            r_scan    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_req_type)
                            rrts_pkg::REQ_LOAD: begin
                                if (can_load) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            rrts_pkg::REQ_TICK: begin
                                r_started <= 1'b1;
                                if (tick_idle) begin
                                    r_state <= ST_OUT;
                                end else begin
                                    r_state <= ST_CHK;
                                end
                            end
                            rrts_pkg::REQ_CLEAR: begin
                                r_count   <= '0;
                                r_cur     <= '0;
                                r_slice   <= '0;
                                r_now     <= '0;
                                r_started <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_CHK: begin
                    if (keep_cur) begin
                        r_state <= ST_RUN;
                    end else begin
                        r_cand  <= cur_next;
                        r_scan  <= CNT_W'(1);
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Take the first candidate with time left
                    if (rem_rdata != '0) begin
                        r_cur   <= r_cand;
                        r_slice <= '0;
                        r_state <= ST_RUN;
                    end else if (r_scan == r_count) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_cand <= cand_next;
                        r_scan <= r_scan + CNT_W'(1);
                    end
                end
                ST_RUN: begin
                    r_slice <= r_slice + QUANT_W'(1);
                    r_now   <= now_inc;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Build the pending result: idle by default, filled in by a run
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) || (r_state == ST_SCAN)) begin
            r_res_slot <= '0;
            r_res_idle <= 1'b1;
            r_res_fin  <= 1'b0;
            r_res_wait <= '0;
            r_res_tat  <= '0;
        end else if (r_state == ST_RUN) begin
            r_res_slot <= SLOT_W'(r_cur);
            r_res_idle <= 1'b0;
            r_res_fin  <= (rem_dec == '0);
            r_res_wait <= (rem_dec == '0) ? wait_val : '0;
            r_res_tat  <= (rem_dec == '0) ? now_inc : '0;
        end
    end

    // Output register: load when the sequencer delivers, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_out_slot <= r_res_slot;
            r_out_idle <= r_res_idle;
            r_out_fin  <= r_res_fin;
            r_out_wait <= r_res_wait;
            r_out_tat  <= r_res_tat;
        end
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_slot_job        = r_out_slot;
    assign o_idle            = r_out_idle;
    assign o_finished        = r_out_fin;
    assign o_wait_time       = r_out_wait;
    assign o_turnaround_time = r_out_tat;

    // APB read back
    assign pready = 1'b1;
    assign prdata = (paddr == rrts_pkg::ADDR_QUANTUM) ? rrts_pkg::APB_DW'(r_quantum) : '0;

endmodule

FILE: rtl/core/rrts_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
